>>> rtl/word_wrap_line_breaker_unit_assert.svh
// Assertion macros shared by the word wrap line breaker modules.
`ifndef WORD_WRAP_LINE_BREAKER_UNIT_ASSERT_SVH
`define WORD_WRAP_LINE_BREAKER_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define WWLB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define WWLB_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wwlb_pkg.sv
`default_nettype none

package wwlb_pkg;

    localparam int WB      = 10;
    localparam int BRK_W   = 6;
    localparam int LCOST_W = 33;
    localparam int BCOST_W = 40;
    localparam int CFG_W   = 2;

    localparam logic [LCOST_W-1:0] LCOST_MAX = {LCOST_W{1'b1}};
    localparam logic [BCOST_W-1:0] BCOST_MAX = {BCOST_W{1'b1}};

    localparam logic [CFG_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_W-1:0] REG_FIRST_PREFIX = 2'd1;
    localparam logic [CFG_W-1:0] REG_LATER_PREFIX = 2'd2;
    localparam logic [CFG_W-1:0] REG_COST_EXP     = 2'd3;

    typedef struct packed {
        logic [WB-1:0] full_width;
        logic [WB-1:0] trimmed_width;
        logic          last_word;
    } in_beat_t;

    typedef struct packed {
        logic [BRK_W-1:0] break_after;
        logic             has_break;
        logic             last_result;
    } out_beat_t;

    typedef struct packed {
        logic store_word;
        logic start_rec;
        logic g_rd;
        logic g_init;
        logic g_step;
        logic j_rd;
        logic j_sum;
        logic s_rd;
        logic s_rem;
        logic pow_step;
        logic s_acc;
        logic j_wr;
        logic b_init;
        logic b_rd;
        logic b_step;
        logic e_init;
        logic e_rd;
        logic e_ld_brk;
        logic e_ld_none;
        logic e_next;
    } cmd_t;

    typedef struct packed {
        logic fits;
        logic greedy;
        logic i_done;
        logic j_done;
        logic pow_done;
        logic s_zero;
        logic pv_ok;
        logic nbrk_zero;
        logic out_last;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/word_wrap_line_breaker_unit.sv
`default_nettype none

// Word wrap line breaker. Words of one record arrive one beat each on the input
// channel, at one beat per cycle, and are kept in on-chip word stores of MAX_WORDS
// entries (later words of an overfull record are dropped, but a dropped last word
// still closes the record). The beat that carries last_word starts the computation:
// a record that fits on the first line yields one result beat with has_break low;
// otherwise cost_exponent 0 fills lines greedily, and 1 to 3 runs a minimum-raggedness
// dynamic program that, for each end word j, visits every candidate line start once,
// using the single-port memories and the one shared multiplier. Break indices then
// leave in ascending order, one result beat at a time, each held until the sink is
// ready, with last_result on the final beat. Input is taken only while the block is
// idle; configuration writes are taken at any time but belong to idle periods.
module word_wrap_line_breaker_unit #(
    parameter int MAX_WORDS = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [wwlb_pkg::CFG_W-1:0]   cfg_idx,
    input  wire  [wwlb_pkg::WB-1:0]      cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wwlb_pkg::in_beat_t           in_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output wwlb_pkg::out_beat_t          out_data
);

    // Command and status bundles between the sequencer and the datapath.
    wwlb_pkg::cmd_t  cmd;
    wwlb_pkg::stat_t stat;

    wwlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_word),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the word and cost memories and the
    // arithmetic; each record step is named by the controller's command, but configuration writes are taken directly.
    wwlb_datapath #(
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/wwlb_datapath.sv
`default_nettype none

module wwlb_datapath #(
    parameter int MAX_WORDS = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [wwlb_pkg::CFG_W-1:0]   cfg_idx,
    input  wire  [wwlb_pkg::WB-1:0]      cfg_data,
    input  wwlb_pkg::in_beat_t           in_data,
    input  wwlb_pkg::cmd_t               cmd,
    output wwlb_pkg::stat_t              stat,
    output wwlb_pkg::out_beat_t          out_data
);

    localparam int WB   = wwlb_pkg::WB;
    localparam int LC   = wwlb_pkg::LCOST_W;
    localparam int BC   = wwlb_pkg::BCOST_W;
    localparam int IDXW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW   = IDXW + 1;
    localparam int SW   = WB + IDXW + 2;
    localparam int PW   = LC + WB;

    // Configuration registers.
    logic [WB-1:0] lw_reg;
    logic [WB-1:0] fp_reg;
    logic [WB-1:0] lp_reg;
    logic [1:0]    exp_reg;

    // Record bookkeeping.
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] tot_reg;
    logic [WB-1:0] lastf_reg;
    logic [WB-1:0] lastt_reg;
    logic [CW-1:0] n_reg;

    // Sequencing and arithmetic registers.
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        j_reg;
    logic [CW-1:0]        s_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] cur_reg;
    logic [WB-1:0]        rem_reg;
    logic                 ok_reg;
    logic                 zero_reg;
    logic [LC-1:0]        cost_reg;
    logic [1:0]           e_reg;
    logic [BC-1:0]        best_reg;
    logic [IDXW-1:0]      bpred_reg;
    logic                 pv_reg;
    logic                 bvalid_reg;
    logic [CW-1:0]        nbrk_reg;
    logic [CW-1:0]        left_reg;
    wwlb_pkg::out_beat_t  out_reg;

    // Memories and their registered read data.
    logic [WB-1:0]   full_mem [MAX_WORDS];
    logic [WB-1:0]   trim_mem [MAX_WORDS];
    logic            dead_mem [MAX_WORDS];
    logic [BC-1:0]   best_mem [MAX_WORDS];
    logic [IDXW:0]   pred_mem [MAX_WORDS];
    logic [IDXW-1:0] brk_mem  [MAX_WORDS];

    logic [WB-1:0]   full_q;
    logic [WB-1:0]   trim_q;
    logic            dead_q;
    logic [BC-1:0]   best_q;
    logic [IDXW:0]   pred_q;
    logic [IDXW-1:0] brk_q;

    logic                 room;
    logic [CW-1:0]        s_m1;
    logic [CW-1:0]        i_m1;
    logic signed [SW-1:0] meas;
    logic signed [SW-1:0] lw_s;
    logic                 g_brk;
    logic signed [SW-1:0] rem_s;
    logic                 ok_c;
    logic [PW-1:0]        prod;
    logic [BC:0]          cand_sum;
    logic [BC-1:0]        cand;
    logic                 push_en;
    logic [IDXW-1:0]      push_val;
    logic [IDXW-1:0]      full_ra;
    logic [IDXW-1:0]      trim_ra;

    assign room  = (cnt_reg < CW'(MAX_WORDS));
    assign s_m1  = s_reg - CW'(1);
    assign i_m1  = i_reg - CW'(1);
    assign lw_s  = $signed(SW'(lw_reg));
    assign meas  = $signed(SW'(fp_reg)) + $signed(tot_reg) - $signed(SW'(lastf_reg))
                 + $signed(SW'(lastt_reg));
    assign g_brk = (cur_reg + $signed(SW'(trim_q))) > lw_s;
    assign rem_s = lw_s - sum_reg
                 - $signed(SW'((s_reg == '0) ? fp_reg : lp_reg));
    assign ok_c  = (s_reg == j_reg) || (!dead_q && (rem_s >= 0));
    assign prod  = PW'(cost_reg) * PW'(rem_reg);
    assign cand_sum = {1'b0, best_q} + (BC+1)'(cost_reg);
    assign cand  = cand_sum[BC] ? wwlb_pkg::BCOST_MAX : cand_sum[BC-1:0];

    assign push_en  = (cmd.g_step && g_brk) || cmd.b_step;
    assign push_val = cmd.b_step ? pred_q[IDXW-1:0] : i_m1[IDXW-1:0];
    assign full_ra  = cmd.s_rd ? s_m1[IDXW-1:0] : i_reg[IDXW-1:0];
    assign trim_ra  = cmd.j_rd ? j_reg[IDXW-1:0] : i_reg[IDXW-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lw_reg  <= WB'(80);
            fp_reg  <= '0;
            lp_reg  <= '0;
            exp_reg <= 2'd2;
            cnt_reg <= '0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_idx)
                    wwlb_pkg::REG_LINE_WIDTH:   lw_reg  <= cfg_data;
                    wwlb_pkg::REG_FIRST_PREFIX: fp_reg  <= cfg_data;
                    wwlb_pkg::REG_LATER_PREFIX: lp_reg  <= cfg_data;
                    wwlb_pkg::REG_COST_EXP:     exp_reg <= cfg_data[1:0];
                    default:                    lw_reg  <= lw_reg;
                endcase
            end
            if (cmd.start_rec) begin
                cnt_reg <= '0;
            end
            else if (cmd.store_word && room) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.start_rec) begin
            tot_reg  <= '0;
            n_reg    <= cnt_reg;
            i_reg    <= '0;
            j_reg    <= '0;
            nbrk_reg <= '0;
        end
        if (cmd.store_word && room) begin
            // The first word of a record restarts the width total.
            tot_reg   <= (cnt_reg == '0) ? SW'(in_data.full_width)
                                         : tot_reg + SW'(in_data.full_width);
            lastf_reg <= in_data.full_width;
            lastt_reg <= in_data.trimmed_width;
        end
        if (cmd.g_init) begin
            cur_reg <= $signed(SW'(fp_reg)) + $signed(SW'(full_q));
            i_reg   <= CW'(1);
        end
        if (cmd.g_step) begin
            if (g_brk) begin
                cur_reg <= $signed(SW'(lp_reg)) + $signed(SW'(full_q));
            end
            else begin
                cur_reg <= cur_reg + $signed(SW'(full_q));
            end
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.j_rd) begin
            s_reg <= j_reg;
        end
        if (cmd.j_sum) begin
            sum_reg    <= $signed(SW'(trim_q));
            pv_reg     <= 1'b0;
            bvalid_reg <= 1'b0;
        end
        if (cmd.s_rem) begin
            ok_reg   <= ok_c;
            zero_reg <= (j_reg == n_reg - CW'(1)) || (rem_s < 0);
            cost_reg <= ((j_reg == n_reg - CW'(1)) || (rem_s < 0)) ? '0 : LC'(1);
            rem_reg  <= rem_s[WB-1:0];
            e_reg    <= '0;
        end
        if (cmd.pow_step) begin
            cost_reg <= (prod > PW'(wwlb_pkg::LCOST_MAX)) ? wwlb_pkg::LCOST_MAX : prod[LC-1:0];
            e_reg    <= e_reg + 2'd1;
        end
        if (cmd.s_acc) begin
            if (ok_reg) begin
                if (s_reg == '0) begin
                    best_reg <= BC'(cost_reg);
                    pv_reg   <= 1'b0;
                end
                else if (!bvalid_reg || (cand <= best_reg)) begin
                    best_reg   <= cand;
                    bpred_reg  <= s_m1[IDXW-1:0];
                    pv_reg     <= 1'b1;
                    bvalid_reg <= 1'b1;
                end
            end
            if (s_reg != '0) begin
                s_reg   <= s_m1;
                sum_reg <= sum_reg + $signed(SW'(full_q));
            end
        end
        if (cmd.j_wr) begin
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.b_init) begin
            i_reg <= n_reg - CW'(1);
        end
        if (cmd.b_step) begin
            i_reg <= CW'(pred_q[IDXW-1:0]);
        end
        if (push_en) begin
            nbrk_reg <= nbrk_reg + CW'(1);
        end
        if (cmd.e_init) begin
            i_reg    <= (exp_reg == 2'd0) ? '0 : nbrk_reg - CW'(1);
            left_reg <= nbrk_reg;
        end
        if (cmd.e_next) begin
            left_reg <= left_reg - CW'(1);
            i_reg    <= (exp_reg == 2'd0) ? i_reg + CW'(1) : i_m1;
        end
        if (cmd.e_ld_brk) begin
            out_reg.break_after <= wwlb_pkg::BRK_W'(brk_q);
            out_reg.has_break   <= 1'b1;
            out_reg.last_result <= (left_reg == CW'(1));
        end
        if (cmd.e_ld_none) begin
            out_reg.break_after <= '0;
            out_reg.has_break   <= 1'b0;
            out_reg.last_result <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.store_word && room) begin
            full_mem[cnt_reg[IDXW-1:0]] <= in_data.full_width;
        end
        if (cmd.g_rd || cmd.s_rd) begin
            full_q <= full_mem[full_ra];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.store_word && room) begin
            trim_mem[cnt_reg[IDXW-1:0]] <= in_data.trimmed_width;
        end
        if (cmd.g_rd || cmd.j_rd) begin
            trim_q <= trim_mem[trim_ra];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.s_rem) begin
            dead_mem[s_reg[IDXW-1:0]] <= !ok_c;
        end
        if (cmd.s_rd) begin
            dead_q <= dead_mem[s_reg[IDXW-1:0]];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.j_wr) begin
            best_mem[j_reg[IDXW-1:0]] <= best_reg;
        end
        if (cmd.s_rd) begin
            best_q <= best_mem[s_m1[IDXW-1:0]];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.j_wr) begin
            pred_mem[j_reg[IDXW-1:0]] <= {pv_reg, bpred_reg};
        end
        if (cmd.b_rd) begin
            pred_q <= pred_mem[i_reg[IDXW-1:0]];
        end
    end

    always_ff @(posedge clk) begin
        if (push_en && (nbrk_reg < CW'(MAX_WORDS))) begin
            brk_mem[nbrk_reg[IDXW-1:0]] <= push_val;
        end
        if (cmd.e_rd) begin
            brk_q <= brk_mem[i_reg[IDXW-1:0]];
        end
    end

    always_comb begin
        stat.fits      = (meas <= lw_s);
        stat.greedy    = (exp_reg == 2'd0);
        stat.i_done    = (i_reg >= n_reg);
        stat.j_done    = (j_reg >= n_reg);
        stat.pow_done  = zero_reg || (e_reg == exp_reg);
        stat.s_zero    = (s_reg == '0);
        stat.pv_ok     = pred_q[IDXW] && (nbrk_reg < CW'(MAX_WORDS));
        stat.nbrk_zero = (nbrk_reg == '0);
        stat.out_last  = out_reg.last_result;
    end

    assign out_data = out_reg;

    `include "word_wrap_line_breaker_unit_assert.svh"

    `WWLB_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(MAX_WORDS), "word count beyond store depth")
    `WWLB_ASSERT_NEXT(a_rec_clear, cmd.start_rec, cnt_reg == '0, "word count not cleared")

endmodule

`default_nettype wire

>>> rtl/wwlb_ctrl.sv
`default_nettype none

module wwlb_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    input  wire              in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  wire              out_ready,
    input  wwlb_pkg::stat_t  stat,
    output wwlb_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_G_RD0,
        ST_G_INIT,
        ST_G_RD,
        ST_G_STEP,
        ST_J_RD,
        ST_J_SUM,
        ST_S_RD,
        ST_S_REM,
        ST_S_POW,
        ST_S_ACC,
        ST_J_WR,
        ST_B_RD,
        ST_B_STEP,
        ST_E_INIT,
        ST_E_RD,
        ST_E_LD,
        ST_ONE,
        ST_E_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.store_word = 1'b1;
                    if (in_last) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cmd.start_rec = 1'b1;
                if (stat.fits) begin
                    state_next = ST_ONE;
                end
                else if (stat.greedy) begin
                    state_next = ST_G_RD0;
                end
                else begin
                    state_next = ST_J_RD;
                end
            end
            ST_G_RD0: begin
                cmd.g_rd   = 1'b1;
                state_next = ST_G_INIT;
            end
            ST_G_INIT: begin
                cmd.g_init = 1'b1;
                state_next = ST_G_RD;
            end
            ST_G_RD: begin
                if (stat.i_done) begin
                    state_next = ST_E_INIT;
                end
                else begin
                    cmd.g_rd   = 1'b1;
                    state_next = ST_G_STEP;
                end
            end
            ST_G_STEP: begin
                cmd.g_step = 1'b1;
                state_next = ST_G_RD;
            end
            ST_J_RD: begin
                if (stat.j_done) begin
                    cmd.b_init = 1'b1;
                    state_next = ST_B_RD;
                end
                else begin
                    cmd.j_rd   = 1'b1;
                    state_next = ST_J_SUM;
                end
            end
            ST_J_SUM: begin
                cmd.j_sum  = 1'b1;
                state_next = ST_S_RD;
            end
            ST_S_RD: begin
                cmd.s_rd   = 1'b1;
                state_next = ST_S_REM;
            end
            ST_S_REM: begin
                cmd.s_rem  = 1'b1;
                state_next = ST_S_POW;
            end
            ST_S_POW: begin
                if (stat.pow_done) begin
                    state_next = ST_S_ACC;
                end
                else begin
                    cmd.pow_step = 1'b1;
                end
            end
            ST_S_ACC: begin
                cmd.s_acc  = 1'b1;
                state_next = stat.s_zero ? ST_J_WR : ST_S_RD;
            end
            ST_J_WR: begin
                cmd.j_wr   = 1'b1;
                state_next = ST_J_RD;
            end
            ST_B_RD: begin
                cmd.b_rd   = 1'b1;
                state_next = ST_B_STEP;
            end
            ST_B_STEP: begin
                if (stat.pv_ok) begin
                    cmd.b_step = 1'b1;
                    state_next = ST_B_RD;
                end
                else begin
                    state_next = ST_E_INIT;
                end
            end
            ST_E_INIT: begin
                if (stat.nbrk_zero) begin
                    state_next = ST_ONE;
                end
                else begin
                    cmd.e_init = 1'b1;
                    state_next = ST_E_RD;
                end
            end
            ST_E_RD: begin
                cmd.e_rd   = 1'b1;
                state_next = ST_E_LD;
            end
            ST_E_LD: begin
                cmd.e_ld_brk = 1'b1;
                state_next   = ST_E_OUT;
            end
            ST_ONE: begin
                cmd.e_ld_none = 1'b1;
                state_next    = ST_E_OUT;
            end
            ST_E_OUT: begin
                if (out_ready) begin
                    if (stat.out_last) begin
                        state_next = ST_IDLE;
                    end
                    else begin
                        cmd.e_next = 1'b1;
                        state_next = ST_E_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_E_OUT);

    `include "word_wrap_line_breaker_unit_assert.svh"

    `WWLB_ASSERT_ALWAYS(a_sides_apart, !(in_ready && out_valid), "input and output open together")
    `WWLB_ASSERT_NEXT(a_last_in_busy, in_valid && in_ready && in_last, !in_ready,
        "block took a word right after the record end")
    `WWLB_ASSERT_NEXT(a_last_out_idle, out_valid && out_ready && stat.out_last, in_ready,
        "block not idle after the final result")

endmodule

`default_nettype wire

>>> test/tb_word_wrap_line_breaker_unit.sv
`default_nettype none

module tb_word_wrap_line_breaker_unit;

    localparam int MAX_WORDS  = 64;
    localparam int IDLE_LIMIT = 200000;
    localparam int SETTLE     = 40;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [wwlb_pkg::CFG_W-1:0]    cfg_idx;
    logic [wwlb_pkg::WB-1:0]       cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    wwlb_pkg::in_beat_t            in_data;
    logic                          out_valid;
    logic                          out_ready;
    wwlb_pkg::out_beat_t           out_data;

    word_wrap_line_breaker_unit #(.MAX_WORDS(MAX_WORDS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Words waiting to be driven, and break beats the block still owes us.
    wwlb_pkg::in_beat_t  word_queue[$];
    wwlb_pkg::out_beat_t break_queue[$];
    int        fail_count;
    int        idle_cycles;
    bit        word_taken;

    // Shadow copy of the configuration registers.
    int unsigned sh_line_width;
    int unsigned sh_first_prefix;
    int unsigned sh_later_prefix;
    int unsigned sh_cost_exp;

    // Shadow copy of the word stores and the dynamic-program tables.
    int unsigned       stored_full[MAX_WORDS];
    int unsigned       stored_trim[MAX_WORDS];
    int                stored_count;
    bit                seg_fits[MAX_WORDS][MAX_WORDS];
    longint unsigned   seg_cost[MAX_WORDS][MAX_WORDS];
    longint unsigned   path_cost[MAX_WORDS];
    int                back_ptr[MAX_WORDS];
    bit                back_ok[MAX_WORDS];

    localparam longint unsigned SEG_SAT  = (64'd1 << 33) - 64'd1;
    localparam longint unsigned PATH_SAT = (64'd1 << 40) - 64'd1;

    // Leftover raised to the cost exponent, clamped after every multiply.
    function automatic longint unsigned raggedness(longint leftover);
        longint unsigned c;
        c = 1;
        for (int e = 0; e < sh_cost_exp; e++)
        begin
            c = c * longint'(leftover);
            if (c > SEG_SAT)
                return SEG_SAT;
        end
        return c;
    endfunction

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > PATH_SAT) ? PATH_SAT : s;
    endfunction

    // Greedy fill: break before any word whose trimmed width overruns the line.
    function automatic void greedy_breaks(int n, ref int brk[$]);
        longint cur;
        cur = longint'(sh_first_prefix) + longint'(stored_full[0]);
        for (int i = 1; i < n; i++)
        begin
            if (cur + longint'(stored_trim[i]) > longint'(sh_line_width))
            begin
                cur = longint'(sh_later_prefix) + longint'(stored_full[i]);
                brk.insert(brk.size(), i - 1);
            end
            else
            begin
                cur += longint'(stored_full[i]);
            end
        end
    endfunction

    // Minimum raggedness: build the segment table, then the best path to each
    // end word, keeping the earliest break on ties, and walk it back.
    function automatic void raggedness_breaks(int n, ref int brk[$]);
        longint          sum;
        longint          rem;
        bit              dead;
        longint unsigned best;
        longint unsigned cand;
        int              i;
        int              j;
        int              path[$];
        for (i = 0; i < n; i++)
        begin
            sum  = 0;
            dead = 0;
            for (j = i; j < n; j++)
            begin
                if (j > i && dead)
                begin
                    seg_fits[i][j] = 0;
                    seg_cost[i][j] = 0;
                    continue;
                end
                if (j > i)
                    sum += longint'(stored_full[j-1]) - longint'(stored_trim[j-1]);
                sum += longint'(stored_trim[j]);
                rem = longint'(sh_line_width) - sum
                    - longint'(i == 0 ? sh_first_prefix : sh_later_prefix);
                seg_cost[i][j] = 0;
                if (j == n - 1)
                    seg_fits[i][j] = (j == i) || rem >= 0;
                else if (j == i)
                begin
                    seg_fits[i][j] = 1;
                    seg_cost[i][j] = (rem < 0) ? 0 : raggedness(rem);
                end
                else
                begin
                    seg_fits[i][j] = rem >= 0;
                    if (rem >= 0)
                        seg_cost[i][j] = raggedness(rem);
                end
                dead = !seg_fits[i][j];
            end
        end
        for (j = 0; j < n; j++)
        begin
            if (seg_fits[0][j])
            begin
                path_cost[j] = seg_cost[0][j];
                back_ok[j]   = 0;
                continue;
            end
            i = 0;
            while (i < j - 1 && !seg_fits[i+1][j])
                i++;
            best = sat_sum(path_cost[i], seg_cost[i+1][j]);
            for (int k = i + 1; k < j; k++)
            begin
                if (!seg_fits[k+1][j])
                    continue;
                cand = sat_sum(path_cost[k], seg_cost[k+1][j]);
                if (cand < best)
                begin
                    best = cand;
                    i    = k;
                end
            end
            path_cost[j] = best;
            back_ptr[j]  = i;
            back_ok[j]   = 1;
        end
        j = n - 1;
        while (back_ok[j] && path.size() < MAX_WORDS)
        begin
            path.push_front(back_ptr[j]);
            j = back_ptr[j];
        end
        foreach (path[p])
            brk.insert(brk.size(), path[p]);
    endfunction

    // Store one accepted word; on the last word, queue the break beats it causes.
    function automatic void predict_word(wwlb_pkg::in_beat_t w);
        int                  n;
        longint              measured;
        int                  brk[$];
        wwlb_pkg::out_beat_t b;
        if (stored_count < MAX_WORDS)
        begin
            stored_full[stored_count] = w.full_width;
            stored_trim[stored_count] = w.trimmed_width;
            stored_count++;
        end
        if (!w.last_word)
            return;
        n = stored_count;
        stored_count = 0;
        measured = longint'(sh_first_prefix);
        for (int i = 0; i < n - 1; i++)
            measured += longint'(stored_full[i]);
        measured += longint'(stored_trim[n-1]);
        if (measured > longint'(sh_line_width))
        begin
            if (sh_cost_exp == 0)
                greedy_breaks(n, brk);
            else
                raggedness_breaks(n, brk);
        end
        if (brk.size() == 0)
        begin
            b.break_after = '0;
            b.has_break   = 1'b0;
            b.last_result = 1'b1;
            break_queue.insert(break_queue.size(), b);
            return;
        end
        foreach (brk[k])
        begin
            b.break_after = brk[k][wwlb_pkg::BRK_W-1:0];
            b.has_break   = 1'b1;
            b.last_result = (k == brk.size() - 1);
            break_queue.insert(break_queue.size(), b);
        end
    endfunction

    // Clock with a 12 unit period.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Input driver. Valid rises in bursts of random length separated by random
    // gaps; once up it holds the word until the block takes it.
    int burst_left;
    int gap_left;

    always @(negedge clk)
    begin
        if (word_taken)
        begin
            void'(word_queue.pop_front());
        end
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || word_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (word_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= word_queue[0];
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        word_taken = 0;
    end

    // Output stall pattern: a random 16-bit mask that rotates each cycle and is
    // sometimes replaced by all ones so that long unstalled stretches occur.
    logic [15:0] stall_mask;
    int          mask_age;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            mask_age++;
            if (mask_age >= 48)
            begin
                mask_age   = 0;
                stall_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
                if (stall_mask == 16'h0)
                    stall_mask = 16'h0001;
            end
            stall_mask = {stall_mask[14:0], stall_mask[15]};
            out_ready <= stall_mask[0];
        end
    end

    // Monitor: predict on accepted words, check every accepted break beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                word_taken = 1;
                predict_word(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (break_queue.size() == 0)
                begin
                    $error("break beat with nothing expected: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    if (out_data.break_after !== break_queue[0].break_after)
                    begin
                        $error("break_after expected %0d got %0d",
                               break_queue[0].break_after, out_data.break_after);
                        fail_count++;
                    end
                    if (out_data.has_break !== break_queue[0].has_break)
                    begin
                        $error("has_break expected %0b got %0b",
                               break_queue[0].has_break, out_data.has_break);
                        fail_count++;
                    end
                    if (out_data.last_result !== break_queue[0].last_result)
                    begin
                        $error("last_result expected %0b got %0b",
                               break_queue[0].last_result, out_data.last_result);
                        fail_count++;
                    end
                    void'(break_queue.pop_front());
                end
            end
        end
    end

    // Watchdog: ends the run with an error once idle_cycles, counted since the last
    // handshake, register write or reset, reaches IDLE_LIMIT.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Register write between records; the shadow copy follows at once.
    task automatic write_reg(logic [wwlb_pkg::CFG_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[wwlb_pkg::WB-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            wwlb_pkg::REG_LINE_WIDTH:   sh_line_width   = value & 10'h3ff;
            wwlb_pkg::REG_FIRST_PREFIX: sh_first_prefix = value & 10'h3ff;
            wwlb_pkg::REG_LATER_PREFIX: sh_later_prefix = value & 10'h3ff;
            default:                    sh_cost_exp     = value & 3;
        endcase
    endtask

    // Wait until every word is taken and every break beat has arrived, then
    // let the block finish any internal work before the registers change.
    task automatic drain;
        while (word_queue.size() != 0 || break_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void queue_word(int unsigned fw, int unsigned tw, bit last);
        wwlb_pkg::in_beat_t w;
        w.full_width    = fw[wwlb_pkg::WB-1:0];
        w.trimmed_width = tw[wwlb_pkg::WB-1:0];
        w.last_word     = last;
        word_queue.insert(word_queue.size(), w);
    endfunction

    // One record of n words. Most words are sized against the current line
    // width so that real wrapping happens; a few are arbitrary noise.
    function automatic int add_record(int n);
        int unsigned fw;
        int unsigned tw;
        int unsigned top;
        top = sh_line_width / 2 + 2;
        if (top > 1023)
            top = 1023;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                fw = $urandom_range(0, 1023);
                tw = $urandom_range(0, 1023);
            end
            else
            begin
                fw = $urandom_range(1, top);
                tw = fw - $urandom_range(0, (fw > 2) ? 2 : fw);
            end
            queue_word(fw, tw, i == n - 1);
        end
        return n;
    endfunction

    int unsigned phase_cfg[10][4];
    int          words_sent;

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        word_taken = 0;
        burst_left = 1;
        gap_left   = 0;
        stall_mask = 16'hb5a3;
        mask_age   = 0;
        stored_count    = 0;
        sh_line_width   = 80;
        sh_first_prefix = 0;
        sh_later_prefix = 0;
        sh_cost_exp     = 2;
        words_sent      = 0;

        phase_cfg = '{'{80, 0, 0, 2}, '{40, 0, 0, 0}, '{60, 3, 5, 1},
                      '{1, 0, 0, 3}, '{1023, 1023, 1023, 2}, '{70, 10, 0, 3},
                      '{1023, 0, 0, 0}, '{50, 0, 1023, 1}, '{0, 0, 0, 0},
                      '{0, 0, 0, 0}};
        for (int p = 8; p < 10; p++)
        begin
            phase_cfg[p][0] = $urandom_range(1, 1023);
            phase_cfg[p][1] = $urandom_range(0, 40);
            phase_cfg[p][2] = $urandom_range(0, 40);
            phase_cfg[p][3] = $urandom_range(0, 3);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed records at the reset configuration.
        // A single short word fits, so no break is made.
        queue_word(5, 4, 1);
        // A single overlong word is alone on its line and still gives no break.
        queue_word(1023, 1023, 1);
        // Widest words, then an empty word at the end of the record.
        queue_word(1023, 1023, 0);
        queue_word(1023, 1023, 0);
        queue_word(0, 0, 1);
        // Trimmed width above the full width.
        queue_word(10, 900, 0);
        queue_word(5, 3, 0);
        queue_word(30, 30, 1);
        // Store overflow: the two words past the store are dropped, and the
        // dropped last word still closes the record.
        for (int i = 0; i < MAX_WORDS + 2; i++)
            queue_word(20, 19, i == MAX_WORDS + 1);

        // Each phase waits for the block to go idle, rewrites the registers
        // (from the second phase on) and sends a batch of random records. The
        // first pause doubles as a full drain before any new word is sent.
        for (int p = 0; p < 10; p++)
        begin
            drain();
            if (p != 0)
            begin
                write_reg(wwlb_pkg::REG_LINE_WIDTH,   phase_cfg[p][0]);
                write_reg(wwlb_pkg::REG_FIRST_PREFIX, phase_cfg[p][1]);
                write_reg(wwlb_pkg::REG_LATER_PREFIX, phase_cfg[p][2]);
                write_reg(wwlb_pkg::REG_COST_EXP,     phase_cfg[p][3]);
            end
            words_sent = 0;
            while (words_sent < 6)
                words_sent += add_record($urandom_range(1, 8));
        end

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
